// ===== rtl/gps_pkg.sv =====
package gps_pkg;

	localparam int GRID_EDGE_DEF     = 16;
	localparam int CELL_CAPACITY_DEF = 16;
	localparam int COORD_BITS_DEF    = 32;

	localparam int COORD_W  = 32;
	localparam int SIZE_W   = 31;
	localparam int GAP_W    = 63;
	localparam int CELLS_W  = 5;
	localparam int STATUS_W = 2;
	localparam int COPIES_W = 5;
	localparam int CFG_A_W  = 3;
	localparam int CFG_D_W  = 63;
	localparam int DVD_W    = COORD_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [STATUS_W-1:0]       status_t;
	typedef logic [COPIES_W-1:0]       copies_t;
	typedef logic [CFG_A_W-1:0]        cfg_addr_t;
	typedef logic [CFG_D_W-1:0]        cfg_data_t;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_OUTSIDE = 2'd1;
	localparam status_t ST_FULL    = 2'd2;

	localparam cfg_addr_t REG_ORIGIN_X  = 3'd0;
	localparam cfg_addr_t REG_ORIGIN_Y  = 3'd1;
	localparam cfg_addr_t REG_ORIGIN_Z  = 3'd2;
	localparam cfg_addr_t REG_CELL_SIZE = 3'd3;
	localparam cfg_addr_t REG_GAP_SQ    = 3'd4;
	localparam cfg_addr_t REG_CELLS_X   = 3'd5;
	localparam cfg_addr_t REG_CELLS_Y   = 3'd6;
	localparam cfg_addr_t REG_CELLS_Z   = 3'd7;

	localparam logic [SIZE_W-1:0]  CELL_SIZE_RST = 31'd196608;
	localparam logic [GAP_W-1:0]   GAP_SQ_RST    = 63'd38654705664;
	localparam logic [CELLS_W-1:0] CELLS_RST     = 5'd16;

endpackage

// ===== rtl/gps_req_if.sv =====
interface gps_req_if;
	import gps_pkg::*;
	logic   valid;
	logic   ready;
	logic   command;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;
	modport source (output valid, command, coord_x, coord_y, coord_z, input ready);
	modport sink   (input valid, command, coord_x, coord_y, coord_z, output ready);
endinterface

// ===== rtl/gps_rsp_if.sv =====
interface gps_rsp_if;
	import gps_pkg::*;
	logic    valid;
	logic    ready;
	logic    hit;
	status_t status;
	copies_t copies_stored;
	modport source (output valid, hit, status, copies_stored, input ready);
	modport sink   (input valid, hit, status, copies_stored, output ready);
endinterface

// ===== rtl/gps_cfg_if.sv =====
interface gps_cfg_if;
	import gps_pkg::*;
	logic      valid;
	logic      ready;
	cfg_addr_t addr;
	cfg_data_t data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

// ===== rtl/gps_ram.sv =====
module gps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/gps_div.sv =====
module gps_div #(
	parameter int DVD_W = 33,
	parameter int DVS_W = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quot,
	output logic [DVS_W-1:0] rem
);
	import gps_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DVD_W-1:0] quot_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	assign trial = {rem_q, quot_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[DVD_W-2:0], ge};
			rem_q  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule

// ===== rtl/grid_proximity_store.sv =====
// Uniform 3-D grid store for close-contact tests on Q16.16 atom positions.
// Channels: req carries a command (insert or query) and a position, rsp
// returns hit, status and copies_stored, one result per request, and cfg
// writes the origin, cell size, squared gap and cell counts by index.
// After reset the cell fill counts are swept to zero, one cell a cycle,
// over all GRID_EDGE**3 cells (4096 by default); req stays low meanwhile
// while cfg writes are taken at any time.
// One request is worked at a time through a shared serial divider and one
// 32x32 squaring multiplier. The cell index takes three divisions, one per
// axis. A query then scans the stored points of its cell; an insert works
// out its face distances, then its own cell and each of the 26 neighbor
// offsets around it.
// The result sits in an output register; the next request is taken while
// it waits, and a finished request holds until rsp is free.
module grid_proximity_store #(
	parameter int GRID_EDGE     = gps_pkg::GRID_EDGE_DEF,
	parameter int CELL_CAPACITY = gps_pkg::CELL_CAPACITY_DEF,
	parameter int COORD_BITS    = gps_pkg::COORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	gps_req_if.sink   req,
	gps_rsp_if.source rsp,
	gps_cfg_if.sink   cfg
);
	import gps_pkg::*;

	localparam int CELLS  = GRID_EDGE * GRID_EDGE * GRID_EDGE;
	localparam int CA_W   = $clog2(CELLS);
	localparam int SLOTS  = CELLS * CELL_CAPACITY;
	localparam int SA_W   = $clog2(SLOTS);
	localparam int FILL_W = $clog2(CELL_CAPACITY + 1);
	localparam int IDX_W  = $clog2(GRID_EDGE);
	localparam int N_W    = IDX_W + 1;
	localparam int NI_W   = IDX_W + 2;
	localparam int ST_W   = 3 * COORD_W;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DIV   = 5'd2;
	localparam logic [4:0] S_DWAIT = 5'd3;
	localparam logic [4:0] S_AXIS  = 5'd4;
	localparam logic [4:0] S_SQ    = 5'd5;
	localparam logic [4:0] S_SQW   = 5'd6;
	localparam logic [4:0] S_NB    = 5'd7;
	localparam logic [4:0] S_SUM   = 5'd8;
	localparam logic [4:0] S_PRD   = 5'd9;
	localparam logic [4:0] S_PWR   = 5'd10;
	localparam logic [4:0] S_NEXT  = 5'd11;
	localparam logic [4:0] S_QRD   = 5'd12;
	localparam logic [4:0] S_QFILL = 5'd13;
	localparam logic [4:0] S_QLOOP = 5'd14;
	localparam logic [4:0] S_QDATA = 5'd15;
	localparam logic [4:0] S_QMUL  = 5'd16;
	localparam logic [4:0] S_QACC  = 5'd17;
	localparam logic [4:0] S_QCMP  = 5'd18;
	localparam logic [4:0] S_FIN   = 5'd19;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	function automatic logic [CA_W-1:0] cell_addr(input logic [IDX_W-1:0] i,
		input logic [IDX_W-1:0] j, input logic [IDX_W-1:0] k);
		return CA_W'((CA_W'(i) * CA_W'(GRID_EDGE) + CA_W'(j)) * CA_W'(GRID_EDGE) + CA_W'(k));
	endfunction

	logic [4:0]         state_q;
	logic [CA_W-1:0]    clr_q;

	coord_t             org_q [3];
	logic [SIZE_W-1:0]  size_q;
	logic [GAP_W-1:0]   gap_q;
	logic [CELLS_W-1:0] cells_q [3];

	logic               cmd_q;
	coord_t             crd_q [3];
	logic [1:0]         ax_q;
	logic               neg_q [3];
	logic [IDX_W-1:0]   idx_q [3];
	logic [SIZE_W-1:0]  dlo_q [3];
	logic [31:0]        dhi_q [3];
	logic [63:0]        sqlo_q [3];
	logic [63:0]        sqhi_q [3];
	logic               hisel_q;
	logic [1:0]         off_q [3];
	logic               own_q;
	logic [63:0]        sxy_q;
	logic [CA_W-1:0]    cell_q;
	logic [FILL_W-1:0]  fcnt_q;
	logic [FILL_W-1:0]  slot_q;
	logic [31:0]        dq_q [3];
	logic [63:0]        acc_q;
	logic [63:0]        mul_p_q;
	logic               outside_q;
	logic               drop_q;
	logic               hit_q;
	copies_t            copies_q;
	logic [31:0]        atoms_q;

	logic               rsp_valid_q;
	logic               rsp_hit_q;
	status_t            rsp_status_q;
	copies_t            rsp_copies_q;

	logic [SIZE_W-1:0]  eff_size;
	logic [N_W-1:0]     eff_n [3];
	logic [DVD_W-1:0]   diff;
	logic [DVD_W-1:0]   mag;
	logic               div_done;
	logic [DVD_W-1:0]   div_quot;
	logic [SIZE_W-1:0]  div_rem;
	logic               ax_in;
	logic [31:0]        mul_op;
	logic [NI_W-1:0]    ni [3];
	logic               nb_in;
	logic               center;
	logic [63:0]        sel [3];
	logic [63:0]        tot;
	logic [63:0]        acc_nx;
	logic [FILL_W-1:0]  fill_rd;
	logic               full;
	logic [ST_W-1:0]    st_rd;
	coord_t             st_c [3];
	logic [DVD_W-1:0]   qd [3];
	logic               fin_go;

	logic               fill_we;
	logic [CA_W-1:0]    fill_wa;
	logic [FILL_W-1:0]  fill_wd;
	logic               fill_re;
	logic               st_we;
	logic [SA_W-1:0]    st_wa;
	logic               st_re;
	logic [SA_W-1:0]    st_ra;

	assign eff_size = (size_q == '0) ? SIZE_W'(1) : size_q;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			eff_n[a] = (32'(cells_q[a]) > GRID_EDGE) ? N_W'(GRID_EDGE) : N_W'(cells_q[a]);
			ni[a]    = NI_W'(idx_q[a]) + NI_W'(off_q[a]) - NI_W'(1);
			unique case (off_q[a])
				2'd0:    sel[a] = sqlo_q[a];
				2'd2:    sel[a] = sqhi_q[a];
				default: sel[a] = '0;
			endcase
			qd[a] = {crd_q[a][COORD_W-1], crd_q[a]} - {st_c[a][COORD_W-1], st_c[a]};
		end
	end

	assign diff = {crd_q[ax_q][COORD_W-1], crd_q[ax_q]} - {org_q[ax_q][COORD_W-1], org_q[ax_q]};
	assign mag  = diff[DVD_W-1] ? (~diff + DVD_W'(1)) : diff;

	assign ax_in = neg_q[ax_q] ? ((div_quot == '0) && (eff_n[ax_q] != '0))
		: (div_quot < DVD_W'(eff_n[ax_q]));

	assign nb_in = !ni[0][NI_W-1] && (ni[0][NI_W-2:0] < eff_n[0])
		&& !ni[1][NI_W-1] && (ni[1][NI_W-2:0] < eff_n[1])
		&& !ni[2][NI_W-1] && (ni[2][NI_W-2:0] < eff_n[2]);
	assign center = (off_q[0] == 2'd1) && (off_q[1] == 2'd1) && (off_q[2] == 2'd1);
	assign tot    = sat_add(sxy_q, sel[2]);
	assign acc_nx = sat_add(acc_q, mul_p_q);
	assign full   = fill_rd >= FILL_W'(CELL_CAPACITY);

	assign st_c[0] = st_rd[3*COORD_W-1:2*COORD_W];
	assign st_c[1] = st_rd[2*COORD_W-1:COORD_W];
	assign st_c[2] = st_rd[COORD_W-1:0];

	always_comb begin
		if (state_q == S_QMUL) begin
			mul_op = dq_q[ax_q];
		end else begin
			mul_op = hisel_q ? dhi_q[ax_q] : 32'(dlo_q[ax_q]);
		end
	end

	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_op) * 64'(mul_op);
	end

	assign fill_we = (state_q == S_CLR) || ((state_q == S_PWR) && !full);
	assign fill_wa = (state_q == S_CLR) ? clr_q : cell_q;
	assign fill_wd = (state_q == S_CLR) ? '0 : fill_rd + FILL_W'(1);
	assign fill_re = (state_q == S_PRD) || (state_q == S_QRD);
	assign st_we   = (state_q == S_PWR) && !full;
	assign st_wa   = SA_W'(SA_W'(cell_q) * SA_W'(CELL_CAPACITY) + SA_W'(fill_rd));
	assign st_re   = (state_q == S_QLOOP);
	assign st_ra   = SA_W'(SA_W'(cell_q) * SA_W'(CELL_CAPACITY) + SA_W'(slot_q));

	gps_ram #(.WIDTH(FILL_W), .DEPTH(CELLS)) u_fill (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_wa),
		.wdata (fill_wd),
		.re    (fill_re),
		.raddr (cell_q),
		.rdata (fill_rd)
	);

	gps_ram #(.WIDTH(ST_W), .DEPTH(SLOTS)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_wa),
		.wdata ({crd_q[0], crd_q[1], crd_q[2]}),
		.re    (st_re),
		.raddr (st_ra),
		.rdata (st_rd)
	);

	gps_div #(.DVD_W(DVD_W), .DVS_W(SIZE_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_DIV),
		.dividend (mag),
		.divisor  (eff_size),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0]   <= '0;
			org_q[1]   <= '0;
			org_q[2]   <= '0;
			size_q     <= CELL_SIZE_RST;
			gap_q      <= GAP_SQ_RST;
			cells_q[0] <= CELLS_RST;
			cells_q[1] <= CELLS_RST;
			cells_q[2] <= CELLS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_ORIGIN_X:  org_q[0]   <= cfg.data[COORD_W-1:0];
				REG_ORIGIN_Y:  org_q[1]   <= cfg.data[COORD_W-1:0];
				REG_ORIGIN_Z:  org_q[2]   <= cfg.data[COORD_W-1:0];
				REG_CELL_SIZE: size_q     <= cfg.data[SIZE_W-1:0];
				REG_GAP_SQ:    gap_q      <= cfg.data[GAP_W-1:0];
				REG_CELLS_X:   cells_q[0] <= cfg.data[CELLS_W-1:0];
				REG_CELLS_Y:   cells_q[1] <= cfg.data[CELLS_W-1:0];
				REG_CELLS_Z:   cells_q[2] <= cfg.data[CELLS_W-1:0];
				default: ;
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign fin_go    = (state_q == S_FIN) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			ax_q        <= '0;
			hisel_q     <= 1'b0;
			own_q       <= 1'b0;
			off_q[0]    <= '0;
			off_q[1]    <= '0;
			off_q[2]    <= '0;
			outside_q   <= 1'b0;
			drop_q      <= 1'b0;
			hit_q       <= 1'b0;
			copies_q    <= '0;
			slot_q      <= '0;
			fcnt_q      <= '0;
			atoms_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CA_W'(1);
					if (clr_q == CA_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						ax_q      <= '0;
						outside_q <= 1'b0;
						drop_q    <= 1'b0;
						hit_q     <= 1'b0;
						copies_q  <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: state_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						if (!ax_in) begin
							outside_q <= 1'b1;
						end
						if (ax_q == 2'd2) begin
							state_q <= S_AXIS;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_DIV;
						end
					end
				end
				S_AXIS: begin
					ax_q    <= '0;
					hisel_q <= 1'b0;
					if (outside_q) begin
						state_q <= S_FIN;
					end else if (cmd_q == CMD_QUERY) begin
						state_q <= S_QRD;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_SQ: state_q <= S_SQW;
				S_SQW: begin
					hisel_q <= !hisel_q;
					if (hisel_q) begin
						if (ax_q == 2'd2) begin
							own_q    <= 1'b1;
							off_q[0] <= 2'd1;
							off_q[1] <= 2'd1;
							off_q[2] <= 2'd1;
							state_q  <= S_NB;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_SQ;
						end
					end else begin
						state_q <= S_SQ;
					end
				end
				S_NB: begin
					if (own_q) begin
						state_q <= S_PRD;
					end else if (center || !nb_in) begin
						state_q <= S_NEXT;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: state_q <= (tot < {1'b0, gap_q}) ? S_PRD : S_NEXT;
				S_PRD: state_q <= S_PWR;
				S_PWR: begin
					if (full) begin
						drop_q <= 1'b1;
					end else begin
						copies_q <= copies_q + COPIES_W'(1);
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					if (own_q) begin
						own_q    <= 1'b0;
						off_q[0] <= '0;
						off_q[1] <= '0;
						off_q[2] <= '0;
						state_q  <= S_NB;
					end else if (off_q[0] == 2'd2 && off_q[1] == 2'd2 && off_q[2] == 2'd2) begin
						atoms_q <= atoms_q + 32'd1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_NB;
						if (off_q[2] != 2'd2) begin
							off_q[2] <= off_q[2] + 2'd1;
						end else begin
							off_q[2] <= '0;
							if (off_q[1] != 2'd2) begin
								off_q[1] <= off_q[1] + 2'd1;
							end else begin
								off_q[1] <= '0;
								off_q[0] <= off_q[0] + 2'd1;
							end
						end
					end
				end
				S_QRD: state_q <= S_QFILL;
				S_QFILL: begin
					fcnt_q  <= fill_rd;
					slot_q  <= '0;
					state_q <= S_QLOOP;
				end
				S_QLOOP: state_q <= (slot_q >= fcnt_q) ? S_FIN : S_QDATA;
				S_QDATA: begin
					ax_q    <= '0;
					state_q <= S_QMUL;
				end
				S_QMUL: state_q <= S_QACC;
				S_QACC: begin
					if (ax_q == 2'd2) begin
						state_q <= S_QCMP;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_QMUL;
					end
				end
				S_QCMP: begin
					if (acc_q < {1'b0, gap_q}) begin
						hit_q   <= 1'b1;
						state_q <= S_FIN;
					end else begin
						slot_q  <= slot_q + FILL_W'(1);
						state_q <= S_QLOOP;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q    <= req.command;
			crd_q[0] <= COORD_W'($signed(req.coord_x[COORD_BITS-1:0]));
			crd_q[1] <= COORD_W'($signed(req.coord_y[COORD_BITS-1:0]));
			crd_q[2] <= COORD_W'($signed(req.coord_z[COORD_BITS-1:0]));
		end
		if (state_q == S_DIV) begin
			neg_q[ax_q] <= diff[DVD_W-1];
		end
		if (state_q == S_DWAIT && div_done) begin
			idx_q[ax_q] <= div_quot[IDX_W-1:0];
			dlo_q[ax_q] <= div_rem;
			dhi_q[ax_q] <= neg_q[ax_q] ? (32'(eff_size) + 32'(div_rem))
				: (32'(eff_size) - 32'(div_rem));
		end
		if (state_q == S_AXIS) begin
			cell_q <= cell_addr(idx_q[0], idx_q[1], idx_q[2]);
		end
		if (state_q == S_SQW) begin
			if (hisel_q) begin
				sqhi_q[ax_q] <= mul_p_q;
			end else begin
				sqlo_q[ax_q] <= mul_p_q;
			end
		end
		if (state_q == S_NB && !own_q) begin
			sxy_q  <= sat_add(sel[0], sel[1]);
			cell_q <= cell_addr(ni[0][IDX_W-1:0], ni[1][IDX_W-1:0], ni[2][IDX_W-1:0]);
		end
		if (state_q == S_QDATA) begin
			acc_q <= '0;
			for (int a = 0; a < 3; a++) begin
				dq_q[a] <= qd[a][DVD_W-1] ? 32'(~qd[a] + DVD_W'(1)) : qd[a][31:0];
			end
		end
		if (state_q == S_QACC) begin
			acc_q <= acc_nx;
		end
		if (fin_go) begin
			rsp_hit_q    <= hit_q;
			rsp_copies_q <= copies_q;
			rsp_status_q <= outside_q ? ST_OUTSIDE : (drop_q ? ST_FULL : ST_OK);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.copies_stored = rsp_copies_q;
endmodule
